[hw/rtl/hvd_pkg.sv]
`default_nettype none
package hvd_pkg;

	localparam int FRAC_BITS_DEF = 23;
	localparam int CORDIC_STEPS = 41;
	localparam int ZW = 44;
	localparam int CW = 32;
	localparam int SQ_W = 61;
	localparam int SQ_STEPS = 31;
	localparam int DIV_STAGES = 2;
	localparam int DEG_XW = 48;
	localparam int LATENCY = 5 + DIV_STAGES + 1 + CORDIC_STEPS + 1 + 4 + SQ_STEPS
		+ CORDIC_STEPS + 2;
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [23:0] TWO_R_M = 24'd12742000;

	typedef struct packed {
		logic want_cos;
		logic neg;
	} rot_tag_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] num_in);
		logic [63:0] num;
		logic [63:0] res;
		logic [63:0] b;
		num = num_in;
		res = 64'd0;
		b = 64'd1 << 62;
		while (b > num) b = b >> 2;
		while (b != 64'd0) begin
			if (num >= res + b) begin
				num = num - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// long division, remainder in the upper half, quotient in the lower
	function automatic logic [127:0] udivmod64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		int i;
		q = 64'd0;
		r = 65'd0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return {r[63:0], q};
	endfunction

	// arctan(2^-i) in q40, from the series in q62
	function automatic logic [63:0] atan_q40(input int unsigned i);
		logic [63:0] sum;
		logic [63:0] term;
		logic [127:0] qr;
		int unsigned k;
		sum = 64'd0;
		if (i == 0) begin
			sum = PI_Q60;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				qr = udivmod64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
				term = qr[63:0];
				if (k[0]) sum = sum - term;
				else sum = sum + term;
			end
		end
		return (sum + (64'd1 << 21)) >> 22;
	endfunction

	function automatic logic [63:0] inv_gain_q40();
		logic [63:0] g;
		logic [63:0] sg;
		logic [63:0] q;
		logic [63:0] r;
		logic [127:0] qr;
		int unsigned i;
		g = 64'd1 << 63;
		for (i = 1; 2 * i <= 62 && i < CORDIC_STEPS; i++) g = g + (g >> (2 * i));
		sg = isqrt64(g);
		qr = udivmod64(64'd1 << 63, sg);
		q = qr[63:0];
		r = qr[127:64];
		qr = udivmod64((r << 8) + (sg >> 1), sg);
		return (q << 8) + qr[63:0];
	endfunction

	localparam logic [63:0] INV_GAIN_Q40 = inv_gain_q40();

endpackage
`default_nettype wire

[hw/rtl/hvd_rot_cell.sv]
`default_nettype none
module hvd_rot_cell #(
	parameter int STEP = 0
) (
	input  wire logic                            clk,
	input  wire logic signed [hvd_pkg::ZW-1:0]   x_in,
	input  wire logic signed [hvd_pkg::ZW-1:0]   y_in,
	input  wire logic signed [hvd_pkg::ZW-1:0]   z_in,
	input  wire hvd_pkg::rot_tag_t               tag_in,
	output logic signed [hvd_pkg::ZW-1:0]        x_q,
	output logic signed [hvd_pkg::ZW-1:0]        y_q,
	output logic signed [hvd_pkg::ZW-1:0]        z_q,
	output hvd_pkg::rot_tag_t                    tag_q
);
	localparam int ZW = hvd_pkg::ZW;
	localparam logic signed [ZW-1:0] ATAN = ZW'(hvd_pkg::atan_q40(STEP));

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (z_in >= 0) begin
			x_q <= x_in - (y_in >>> STEP);
			y_q <= y_in + (x_in >>> STEP);
			z_q <= z_in - ATAN;
		end else begin
			x_q <= x_in + (y_in >>> STEP);
			y_q <= y_in - (x_in >>> STEP);
			z_q <= z_in + ATAN;
		end
		tag_q <= tag_in;
	end
endmodule
`default_nettype wire

[hw/rtl/hvd_vec_cell.sv]
`default_nettype none
module hvd_vec_cell #(
	parameter int STEP = 0
) (
	input  wire logic                            clk,
	input  wire logic signed [hvd_pkg::ZW-1:0]   x_in,
	input  wire logic signed [hvd_pkg::ZW-1:0]   y_in,
	input  wire logic signed [hvd_pkg::ZW-1:0]   z_in,
	output logic signed [hvd_pkg::ZW-1:0]        x_q,
	output logic signed [hvd_pkg::ZW-1:0]        y_q,
	output logic signed [hvd_pkg::ZW-1:0]        z_q
);
	localparam int ZW = hvd_pkg::ZW;
	localparam logic signed [ZW-1:0] ATAN = ZW'(hvd_pkg::atan_q40(STEP));

	// drive y toward zero, accumulate the angle
	always_ff @(posedge clk) begin
		if (y_in > 0) begin
			x_q <= x_in + (y_in >>> STEP);
			y_q <= y_in - (x_in >>> STEP);
			z_q <= z_in + ATAN;
		end else begin
			x_q <= x_in - (y_in >>> STEP);
			y_q <= y_in + (x_in >>> STEP);
			z_q <= z_in - ATAN;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/hvd_sqrt_cell.sv]
`default_nettype none
module hvd_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic                      clk,
	input  wire logic [hvd_pkg::SQ_W-1:0]  num_in,
	input  wire logic [hvd_pkg::SQ_W-1:0]  res_in,
	output logic [hvd_pkg::SQ_W-1:0]       num_q,
	output logic [hvd_pkg::SQ_W-1:0]       res_q
);
	localparam int SW = hvd_pkg::SQ_W;
	localparam logic [SW:0] BIT = (SW + 1)'(1) << (SW - 1 - 2 * STEP);

	logic [SW:0] trial;

	assign trial = {1'b0, res_in} + BIT;

	always_ff @(posedge clk) begin
		if ({1'b0, num_in} >= trial) begin
			num_q <= num_in - trial[SW-1:0];
			res_q <= (res_in >> 1) + BIT[SW-1:0];
		end else begin
			num_q <= num_in;
			res_q <= res_in >> 1;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/haversine_distance_unit.sv]
// throughput: one position pair per cycle, busy stays low
// the rate comes from the rows of cordic and square root cells and the two stage divide
// every cell takes one step of one word per cycle, so words overlap fully
// reset clears only the valid flags down the pipeline, no clearing pass
`default_nettype none
module haversine_distance_unit #(
	parameter int FRAC_BITS = hvd_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [30:0] lat_a,
	input  wire logic signed [31:0] lon_a,
	input  wire logic signed [30:0] lat_b,
	input  wire logic signed [31:0] lon_b,
	output logic                    done,
	output logic [24:0]             distance_m
);
	localparam int ZW = hvd_pkg::ZW;
	localparam int CW = hvd_pkg::CW;
	localparam int SW = hvd_pkg::SQ_W;
	localparam int NS = hvd_pkg::CORDIC_STEPS;
	localparam int NQ = hvd_pkg::SQ_STEPS;
	localparam int XW = hvd_pkg::DEG_XW;
	localparam int LAT = hvd_pkg::LATENCY;

	localparam logic [63:0] P360 = 64'd360 << FRAC_BITS;
	localparam logic [63:0] HALF = 64'd180 << FRAC_BITS;
	localparam logic [63:0] QUART = 64'd90 << FRAC_BITS;
	localparam int AW = $clog2(HALF + 64'd1);
	localparam int RW = AW + 1;
	localparam logic [63:0] NOFF = ((64'd1 << 32) + P360 - 64'd1) / P360;
	localparam logic [63:0] OFF = NOFF * P360;
	localparam logic [63:0] UMAX = (64'd1 << 32) + OFF;
	localparam int RSTEPS = $clog2(UMAX / P360 + 64'd1);
	localparam int UW = $clog2(UMAX + 64'd1);
	localparam logic signed [RW-1:0] HALF_S = RW'(HALF);
	localparam logic signed [RW-1:0] QUART_S = RW'(QUART);
	localparam logic [30:0] PI_LO = hvd_pkg::PI_Q60[30:0];
	localparam logic [30:0] PI_HI = hvd_pkg::PI_Q60[61:31];
	localparam int PW = AW + 62;
	// 22528/1024 of the rounding term, the rest comes from bit 9 of the quotient
	localparam logic [XW-1:0] RND_BIAS = XW'(22);
	// 2^12 is one more than a multiple of 45, so each 12-bit digit splits cleanly
	localparam logic [30:0] DIV_C36 = 31'd1527099483;
	localparam logic [18:0] DIV_C24 = 19'd372827;
	localparam logic [6:0] DIV_C12 = 7'd91;
	// ceil(2^20/45), exact for digit sums below 2^14
	localparam logic [14:0] DIV_RCP = 15'd23302;
	localparam logic signed [ZW-1:0] INV_GAIN = ZW'(hvd_pkg::INV_GAIN_Q40);
	localparam logic signed [ZW-1:0] Q30_RND = ZW'(512);
	localparam logic [SW-1:0] ONE_Q60 = SW'(1) << 60;

	// reduce to (-180,180] degrees
	function automatic logic signed [RW-1:0] reduce360(input logic signed [33:0] d);
		logic [UW-1:0] u;
		int i;
		u = UW'(d) + UW'(OFF);
		for (i = RSTEPS - 1; i >= 0; i--) begin
			if (u >= UW'(P360 << i)) u = u - UW'(P360 << i);
		end
		if (u > UW'(HALF)) return RW'(u) - RW'(P360);
		return RW'(u);
	endfunction

	logic                 acc;
	logic [LAT-1:0]       vld_q;
	logic signed [CW-1:0] rot_v [4];

	assign busy = 1'b0;
	assign acc = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	// channels: half lat difference, half lon difference, lat a, lat b
	for (genvar c = 0; c < 4; c++) begin : g_ch
		localparam bit IS_HALF = (c < 2);
		localparam int SH = IS_HALF ? FRAC_BITS + 13 : FRAC_BITS + 12;

		logic signed [33:0]   d_in;
		logic signed [33:0]   d_s1;
		logic signed [RW-1:0] r_s2;
		logic signed [RW-1:0] fold;
		logic                 fneg;
		logic [AW-1:0]        mag_s3;
		logic                 sgn_s3, neg_s3;
		logic [AW+30:0]       plo_s4, phi_s4;
		logic                 sgn_s4, neg_s4;
		logic [PW-1:0]        prod;
		logic [XW-1:0]        x_s5;
		logic                 sgn_s5, neg_s5;
		logic [42:0]          pa_s6;
		logic [30:0]          pb_s6;
		logic [18:0]          pc_s6;
		logic [13:0]          sm_s6;
		logic                 sgn_s6, neg_s6;
		logic [28:0]          fr_prod;
		logic [XW-1:0]        q_s7;
		logic                 sgn_s7, neg_s7;
		logic signed [ZW-1:0] z_th_q;
		hvd_pkg::rot_tag_t    tag_th_q;
		logic signed [ZW-1:0] rx [NS+1];
		logic signed [ZW-1:0] ry [NS+1];
		logic signed [ZW-1:0] rz [NS+1];
		hvd_pkg::rot_tag_t    rt [NS+1];
		logic signed [ZW-1:0] sv, cv;
		logic signed [CW-1:0] v_ro_q;

		if (c == 0) begin : g_d0
			assign d_in = 34'(lat_b) - 34'(lat_a);
		end else if (c == 1) begin : g_d1
			assign d_in = 34'(lon_b) - 34'(lon_a);
		end else if (c == 2) begin : g_d2
			assign d_in = 34'(lat_a);
		end else begin : g_d3
			assign d_in = 34'(lat_b);
		end

		// latitudes fold into [-90,90], with the cosine negated when folded
		always_comb begin
			fold = r_s2;
			fneg = 1'b0;
			if (!IS_HALF) begin
				if (r_s2 > QUART_S) begin
					fold = HALF_S - r_s2;
					fneg = 1'b1;
				end else if (r_s2 < -QUART_S) begin
					fold = -HALF_S - r_s2;
					fneg = 1'b1;
				end
			end
		end

		assign prod = {phi_s4, 31'd0} + PW'(plo_s4);
		assign fr_prod = sm_s6 * DIV_RCP;

		always_ff @(posedge clk) begin
			d_s1 <= d_in;
			r_s2 <= reduce360(d_s1);
			mag_s3 <= (fold < 0) ? AW'(-fold) : AW'(fold);
			sgn_s3 <= fold < 0;
			neg_s3 <= fneg;
			plo_s4 <= mag_s3 * PI_LO;
			phi_s4 <= mag_s3 * PI_HI;
			sgn_s4 <= sgn_s3;
			neg_s4 <= neg_s3;
			x_s5 <= XW'(prod >> (SH + 10)) + RND_BIAS + XW'(prod[SH+9]);
			sgn_s5 <= sgn_s4;
			neg_s5 <= neg_s4;
			// divide by 45: whole multiples per digit, then the digit sum
			pa_s6 <= x_s5[47:36] * DIV_C36;
			pb_s6 <= x_s5[35:24] * DIV_C24;
			pc_s6 <= x_s5[23:12] * DIV_C12;
			sm_s6 <= 14'(x_s5[47:36]) + 14'(x_s5[35:24]) + 14'(x_s5[23:12])
				+ 14'(x_s5[11:0]);
			sgn_s6 <= sgn_s5;
			neg_s6 <= neg_s5;
			q_s7 <= XW'(pa_s6) + XW'(pb_s6) + XW'(pc_s6) + XW'(fr_prod[28:20]);
			sgn_s7 <= sgn_s6;
			neg_s7 <= neg_s6;
			z_th_q <= sgn_s7 ? -ZW'(q_s7) : ZW'(q_s7);
			tag_th_q <= '{want_cos: !IS_HALF, neg: neg_s7};
		end

		assign rx[0] = INV_GAIN;
		assign ry[0] = '0;
		assign rz[0] = z_th_q;
		assign rt[0] = tag_th_q;

		for (genvar k = 0; k < NS; k++) begin : g_rot
			hvd_rot_cell #(.STEP(k)) u_cell (
				.clk    (clk),
				.x_in   (rx[k]),
				.y_in   (ry[k]),
				.z_in   (rz[k]),
				.tag_in (rt[k]),
				.x_q    (rx[k+1]),
				.y_q    (ry[k+1]),
				.z_q    (rz[k+1]),
				.tag_q  (rt[k+1])
			);
		end

		assign sv = (ry[NS] + Q30_RND) >>> 10;
		assign cv = (rx[NS] + Q30_RND) >>> 10;

		always_ff @(posedge clk) begin
			if (rt[NS].want_cos) begin
				v_ro_q <= rt[NS].neg ? -CW'(cv) : CW'(cv);
			end else begin
				v_ro_q <= CW'(sv);
			end
		end

		assign rot_v[c] = v_ro_q;
	end

	// products of the haversine term
	logic signed [63:0] cc_p_m1, ss_m1, ss_m2, ss_m3;
	logic signed [CW-1:0] t_m1, t_m2;
	logic signed [33:0] cc_w;
	logic signed [65:0] p2_m2;
	logic signed [35:0] u_w;
	logic signed [67:0] ut_m3;
	logic signed [68:0] a_sum;
	logic [SW-1:0] a_m4, na_m4;

	assign cc_w = 34'((cc_p_m1 + 64'sd536870912) >>> 30);
	assign u_w = 36'((p2_m2 + 66'sd536870912) >>> 30);
	assign a_sum = 69'(ss_m3) + 69'(ut_m3);

	always_ff @(posedge clk) begin
		cc_p_m1 <= rot_v[2] * rot_v[3];
		ss_m1 <= rot_v[0] * rot_v[0];
		t_m1 <= rot_v[1];
		p2_m2 <= cc_w * t_m1;
		ss_m2 <= ss_m1;
		t_m2 <= t_m1;
		ut_m3 <= u_w * t_m2;
		ss_m3 <= ss_m2;
		if (a_sum < 0) begin
			a_m4 <= '0;
			na_m4 <= ONE_Q60;
		end else if (a_sum > 69'(ONE_Q60)) begin
			a_m4 <= ONE_Q60;
			na_m4 <= '0;
		end else begin
			a_m4 <= SW'(a_sum);
			na_m4 <= ONE_Q60 - SW'(a_sum);
		end
	end

	// square roots of a and of 1-a
	logic [30:0] sq_v [2];

	for (genvar j = 0; j < 2; j++) begin : g_sq
		logic [SW-1:0] sn [NQ+1];
		logic [SW-1:0] sr [NQ+1];

		assign sn[0] = (j == 0) ? a_m4 : na_m4;
		assign sr[0] = '0;

		for (genvar k = 0; k < NQ; k++) begin : g_cell
			hvd_sqrt_cell #(.STEP(k)) u_cell (
				.clk    (clk),
				.num_in (sn[k]),
				.res_in (sr[k]),
				.num_q  (sn[k+1]),
				.res_q  (sr[k+1])
			);
		end

		assign sq_v[j] = sr[NQ][30:0];
	end

	// atan2(sqrt(a), sqrt(1-a))
	logic signed [ZW-1:0] vx [NS+1];
	logic signed [ZW-1:0] vy [NS+1];
	logic signed [ZW-1:0] vz [NS+1];

	assign vx[0] = {3'd0, sq_v[1], 10'd0};
	assign vy[0] = {3'd0, sq_v[0], 10'd0};
	assign vz[0] = '0;

	for (genvar k = 0; k < NS; k++) begin : g_vec
		hvd_vec_cell #(.STEP(k)) u_cell (
			.clk  (clk),
			.x_in (vx[k]),
			.y_in (vy[k]),
			.z_in (vz[k]),
			.x_q  (vx[k+1]),
			.y_q  (vy[k+1]),
			.z_q  (vz[k+1])
		);
	end

	// scale the angle to meters
	logic [ZW-1:0] zc;
	logic [39:0] zq;
	logic [43:0] plo_f1, phi_f1;
	logic [64:0] dsum;
	logic [28:0] dfull;
	logic [24:0] dist_f2;

	assign zc = (vz[NS] < 0) ? '0 : ZW'(vz[NS]);
	assign zq = 40'((zc + ZW'(8)) >> 4);
	assign dsum = {1'b0, phi_f1, 20'd0} + 65'(plo_f1) + (65'd1 << 35);
	assign dfull = 29'(dsum >> 36);

	always_ff @(posedge clk) begin
		plo_f1 <= hvd_pkg::TWO_R_M * zq[19:0];
		phi_f1 <= hvd_pkg::TWO_R_M * zq[39:20];
		dist_f2 <= (dfull[28:25] != 4'd0) ? '1 : dfull[24:0];
	end

	assign done = vld_q[LAT-1];
	assign distance_m = dist_f2;
endmodule
`default_nettype wire

[hw/rtl/haversine_distance_unit_chk.sv]
`default_nettype none
module haversine_distance_unit_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic signed [30:0] lat_a,
	input wire logic signed [31:0] lon_a,
	input wire logic signed [30:0] lat_b,
	input wire logic signed [31:0] lon_b,
	input wire logic               done,
	input wire logic [24:0]        distance_m
);
	localparam int LAT = hvd_pkg::LATENCY;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word lost");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a word");

	a_same_point: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && lat_a == lat_b && lon_a == lon_b) |-> ##LAT (distance_m == 25'd0))
		else $error("coincident points not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (distance_m <= 25'd20015090))
		else $error("distance beyond half circumference");
endmodule

bind haversine_distance_unit haversine_distance_unit_chk u_chk (.*);
`default_nettype wire
